### rtl/armv5_instruction_classifier_macros.svh
// Assertion macros shared by the classifier RTL.
// Each macro expands to one labeled concurrent assertion that is sampled on
// the rising clock edge and is switched off while reset is asserted.
`ifndef ARMV5_INSTRUCTION_CLASSIFIER_MACROS_SVH
`define ARMV5_INSTRUCTION_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("classifier check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define AIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("classifier check failed one cycle later");

`endif

### rtl/aic_pkg.sv
package aic_pkg;

    // Instruction classes, numbered as the result field reports them.
    typedef enum logic [4:0] {
        CLS_UNKNOWN      = 5'd0,
        CLS_MSR_REG      = 5'd1,
        CLS_MRS          = 5'd2,
        CLS_DP_SHIFT_IMM = 5'd3,
        CLS_BX           = 5'd4,
        CLS_CLZ          = 5'd5,
        CLS_DP_SHIFT_REG = 5'd6,
        CLS_MUL          = 5'd7,
        CLS_MUL_LONG     = 5'd8,
        CLS_SWP          = 5'd9,
        CLS_LDRH_IMM     = 5'd10,
        CLS_LDRH_REG     = 5'd11,
        CLS_LDRSB_IMM    = 5'd12,
        CLS_LDRSB_REG    = 5'd13,
        CLS_LDRSH_IMM    = 5'd14,
        CLS_LDRSH_REG    = 5'd15,
        CLS_MSR_IMM      = 5'd16,
        CLS_DP_IMM       = 5'd17,
        CLS_LDR_IMM      = 5'd18,
        CLS_LDR_REG      = 5'd19,
        CLS_LDM          = 5'd20,
        CLS_B            = 5'd21,
        CLS_SWI          = 5'd22,
        CLS_MCR          = 5'd23
    } class_code_t;

    // Major instruction groups, bits 27 to 25.
    localparam logic [2:0] GRP_DP_REG    = 3'd0;
    localparam logic [2:0] GRP_DP_IMM    = 3'd1;
    localparam logic [2:0] GRP_LS_IMM    = 3'd2;
    localparam logic [2:0] GRP_LS_REG    = 3'd3;
    localparam logic [2:0] GRP_LDM       = 3'd4;
    localparam logic [2:0] GRP_BRANCH    = 3'd5;
    localparam logic [2:0] GRP_CP_LS     = 3'd6;
    localparam logic [2:0] GRP_SWI_CP    = 3'd7;

    // Extra load and store kinds, bits 6 to 5 when bits 7 and 4 are set.
    localparam logic [1:0] XLS_SWP_MUL   = 2'd0;
    localparam logic [1:0] XLS_HALF      = 2'd1;
    localparam logic [1:0] XLS_SBYTE     = 2'd2;
    localparam logic [1:0] XLS_SHALF     = 2'd3;

    // Multiply kinds, bits 24 to 23.
    localparam logic [1:0] MULK_SHORT    = 2'd0;
    localparam logic [1:0] MULK_LONG     = 2'd1;
    localparam logic [1:0] MULK_MISC     = 2'd2;

    localparam logic [3:0] COND_NEVER    = 4'hf;
    localparam logic [3:0] OPC_CLZ       = 4'hb;

    // Pattern masks and matches over the instruction word.
    localparam logic [31:0] MASK_MSR_REG   = 32'h01b0ffe0;
    localparam logic [31:0] MATCH_MSR      = 32'h0120f000;
    localparam logic [31:0] MASK_MRS       = 32'h01bf0fff;
    localparam logic [31:0] MATCH_MRS      = 32'h010f0000;
    localparam logic [31:0] MASK_BX        = 32'h01ffffc0;
    localparam logic [31:0] MATCH_BX       = 32'h012fff00;
    localparam logic [31:0] MASK_MSR_IMM   = 32'h01b0f000;
    localparam logic [31:0] MASK_STATUS    = 32'h01b00000;
    localparam logic [31:0] MATCH_STATUS   = 32'h01000000;

    // The pipeline runs two words ahead of the instruction being executed.
    localparam logic [31:0] PC_AHEAD       = 32'd8;

    // Everything the decoder gives for one instruction.
    typedef struct packed {
        class_code_t class_code;
        logic [3:0]  condition;
        logic [3:0]  dest_reg;
        logic [3:0]  first_reg;
        logic [3:0]  second_reg;
        logic [3:0]  shift_reg;
        logic [3:0]  alu_opcode;
        logic [1:0]  shift_kind;
        logic [4:0]  shift_count;
        logic [4:0]  flag_bits;
        logic [31:0] immediate;
        logic [31:0] branch_target;
    } decode_result_t;

endpackage

### rtl/aic_channels.sv
// Request channel into the classifier: one instruction and its address.
interface aic_fetch_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [31:0] fetch_address;

    modport source (output valid, output instruction, output fetch_address, input ready);
    modport sink   (input valid, input instruction, input fetch_address, output ready);
endinterface

// Result channel out of the classifier.
interface aic_decode_if;
    logic        valid;
    logic        ready;
    logic [4:0]  class_code;
    logic [3:0]  condition;
    logic [3:0]  dest_reg;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [3:0]  shift_reg;
    logic [3:0]  alu_opcode;
    logic [1:0]  shift_kind;
    logic [4:0]  shift_count;
    logic [4:0]  flag_bits;
    logic [31:0] immediate;
    logic [31:0] branch_target;

    modport source (
        output valid, output class_code, output condition, output dest_reg,
        output first_reg, output second_reg, output shift_reg, output alu_opcode,
        output shift_kind, output shift_count, output flag_bits, output immediate,
        output branch_target, input ready
    );
    modport sink (
        input valid, input class_code, input condition, input dest_reg,
        input first_reg, input second_reg, input shift_reg, input alu_opcode,
        input shift_kind, input shift_count, input flag_bits, input immediate,
        input branch_target, output ready
    );
endinterface

### rtl/aic_decode.sv
// Combinational decode of one instruction word into class, fields,
// immediate and branch target.
module aic_decode (
    input  logic [31:0]             instruction,
    input  logic [31:0]             fetch_address,
    output aic_pkg::decode_result_t result
);

    aic_pkg::class_code_t cls;
    logic [31:0] w;
    logic [31:0] rot_base;
    logic [63:0] rot_wide;
    logic [4:0]  rot_amt;
    logic [31:0] imm;
    logic [31:0] branch_offset;

    assign w = instruction;

    always_comb
    begin
        cls = aic_pkg::CLS_UNKNOWN;
        unique case (w[27:25])
            aic_pkg::GRP_DP_REG:
            begin
                if (!w[4])
                begin
                    if ((w & aic_pkg::MASK_MSR_REG) == aic_pkg::MATCH_MSR)
                        cls = aic_pkg::CLS_MSR_REG;
                    else if ((w & aic_pkg::MASK_MRS) == aic_pkg::MATCH_MRS)
                        cls = aic_pkg::CLS_MRS;
                    else
                        cls = aic_pkg::CLS_DP_SHIFT_IMM;
                end
                else if (!w[7])
                begin
                    if (w[24:23] == aic_pkg::MULK_MISC && !w[20])
                    begin
                        if ((w & aic_pkg::MASK_BX) == aic_pkg::MATCH_BX)
                            cls = aic_pkg::CLS_BX;
                        else if (!w[6] && !w[5] && w[24:21] == aic_pkg::OPC_CLZ)
                            cls = aic_pkg::CLS_CLZ;
                    end
                    else
                    begin
                        cls = aic_pkg::CLS_DP_SHIFT_REG;
                    end
                end
                else
                begin
                    unique case (w[6:5])
                        aic_pkg::XLS_SWP_MUL:
                        begin
                            if (w[24:23] == aic_pkg::MULK_SHORT)
                            begin
                                if (!w[22])
                                    cls = aic_pkg::CLS_MUL;
                            end
                            else if (w[24:23] == aic_pkg::MULK_LONG)
                                cls = aic_pkg::CLS_MUL_LONG;
                            else if (w[24:23] == aic_pkg::MULK_MISC && !w[20] && !w[21]
                                     && w[11:8] == 4'd0)
                                cls = aic_pkg::CLS_SWP;
                        end
                        aic_pkg::XLS_HALF:
                        begin
                            if (w[22])
                                cls = aic_pkg::CLS_LDRH_IMM;
                            else if (w[11:8] == 4'd0)
                                cls = aic_pkg::CLS_LDRH_REG;
                        end
                        aic_pkg::XLS_SBYTE:
                        begin
                            if (!w[20])
                                cls = aic_pkg::CLS_UNKNOWN;
                            else if (w[22])
                                cls = aic_pkg::CLS_LDRSB_IMM;
                            else if (w[11:8] == 4'd0)
                                cls = aic_pkg::CLS_LDRSB_REG;
                        end
                        aic_pkg::XLS_SHALF:
                        begin
                            if (!w[20])
                                cls = aic_pkg::CLS_UNKNOWN;
                            else if (w[22])
                                cls = aic_pkg::CLS_LDRSH_IMM;
                            else if (w[11:8] == 4'd0)
                                cls = aic_pkg::CLS_LDRSH_REG;
                        end
                        default: cls = aic_pkg::CLS_UNKNOWN;
                    endcase
                end
            end
            aic_pkg::GRP_DP_IMM:
            begin
                if ((w & aic_pkg::MASK_MSR_IMM) == aic_pkg::MATCH_MSR)
                    cls = aic_pkg::CLS_MSR_IMM;
                else if ((w & aic_pkg::MASK_STATUS) != aic_pkg::MATCH_STATUS)
                    cls = aic_pkg::CLS_DP_IMM;
            end
            aic_pkg::GRP_LS_IMM: cls = aic_pkg::CLS_LDR_IMM;
            aic_pkg::GRP_LS_REG:
            begin
                if (!w[4])
                    cls = aic_pkg::CLS_LDR_REG;
            end
            aic_pkg::GRP_LDM:    cls = aic_pkg::CLS_LDM;
            aic_pkg::GRP_BRANCH: cls = aic_pkg::CLS_B;
            aic_pkg::GRP_CP_LS:  cls = aic_pkg::CLS_UNKNOWN;
            aic_pkg::GRP_SWI_CP:
            begin
                if (w[24])
                    cls = aic_pkg::CLS_SWI;
                else if (w[4])
                    cls = aic_pkg::CLS_MCR;
            end
            default: cls = aic_pkg::CLS_UNKNOWN;
        endcase
        // The never condition overrides every encoding.
        if (w[31:28] == aic_pkg::COND_NEVER)
            cls = aic_pkg::CLS_UNKNOWN;
    end

    // Rotate the 8-bit immediate right by twice the rotate field. A doubled
    // word shifted right gives the rotation, and a zero amount leaves it as is.
    assign rot_base = {24'd0, w[7:0]};
    assign rot_amt  = {w[11:8], 1'b0};
    assign rot_wide = {rot_base, rot_base} >> rot_amt;

    always_comb
    begin
        unique case (cls)
            aic_pkg::CLS_MSR_IMM,
            aic_pkg::CLS_DP_IMM:    imm = rot_wide[31:0];
            aic_pkg::CLS_LDR_IMM:   imm = {20'd0, w[11:0]};
            aic_pkg::CLS_LDRH_IMM,
            aic_pkg::CLS_LDRSB_IMM,
            aic_pkg::CLS_LDRSH_IMM: imm = {24'd0, w[11:8], w[3:0]};
            aic_pkg::CLS_SWI:       imm = {8'd0, w[23:0]};
            default:                imm = 32'd0;
        endcase
    end

    assign branch_offset = {{6{w[23]}}, w[23:0], 2'b00};

    always_comb
    begin
        result.class_code    = cls;
        result.condition     = w[31:28];
        result.dest_reg      = w[15:12];
        result.first_reg     = w[19:16];
        result.second_reg    = w[3:0];
        result.shift_reg     = w[11:8];
        result.alu_opcode    = w[24:21];
        result.shift_kind    = w[6:5];
        result.shift_count   = w[11:7];
        result.flag_bits     = w[24:20];
        result.immediate     = imm;
        result.branch_target = (cls == aic_pkg::CLS_B)
                             ? fetch_address + aic_pkg::PC_AHEAD + branch_offset
                             : 32'd0;
    end

endmodule

### rtl/armv5_instruction_classifier.sv
// Channel   Direction  Contents
// fetch     in         instruction word and the address it was fetched from
// decode    out        class code, register/shift/flag fields, immediate, target
//
// A request is accepted into the input register, decoded into the result
// register and can be taken from there. A new request is accepted every cycle
// while the input slot is free. A stalled result holds the result register, and
// the input register still takes one more request while its own slot is free.
// Reset clears both valid flags; the payload registers are not reset.
module armv5_instruction_classifier (
    input  logic              clk,
    input  logic              rst_n,
    aic_fetch_if.sink         fetch,
    aic_decode_if.source      decode
);

`include "armv5_instruction_classifier_macros.svh"

    // Input stage. It holds one request while the decoder works on it.
    logic        in_valid_reg;
    logic [31:0] in_instr_reg;
    logic [31:0] in_addr_reg;

    // Result stage. It drives the decode channel directly, so the outputs
    // come straight from flops.
    logic                     out_valid_reg;
    aic_pkg::decode_result_t  out_result_reg;
    aic_pkg::decode_result_t  out_result_next;

    logic fetch_accept;
    logic out_free;
    logic in_free;

    // The result slot frees when it is empty or is taken this cycle. The
    // input slot frees when it is empty or moves into the result slot.
    assign out_free     = !out_valid_reg || decode.ready;
    assign in_free      = !in_valid_reg || out_free;
    assign fetch.ready  = in_free;
    assign fetch_accept = fetch.valid && in_free;

    aic_decode u_decode (
        .instruction   (in_instr_reg),
        .fetch_address (in_addr_reg),
        .result        (out_result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= fetch.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch_accept)
        begin
            in_instr_reg <= fetch.instruction;
            in_addr_reg  <= fetch.fetch_address;
        end
        if (out_free && in_valid_reg)
            out_result_reg <= out_result_next;
    end

    assign decode.valid         = out_valid_reg;
    assign decode.class_code    = out_result_reg.class_code;
    assign decode.condition     = out_result_reg.condition;
    assign decode.dest_reg      = out_result_reg.dest_reg;
    assign decode.first_reg     = out_result_reg.first_reg;
    assign decode.second_reg    = out_result_reg.second_reg;
    assign decode.shift_reg     = out_result_reg.shift_reg;
    assign decode.alu_opcode    = out_result_reg.alu_opcode;
    assign decode.shift_kind    = out_result_reg.shift_kind;
    assign decode.shift_count   = out_result_reg.shift_count;
    assign decode.flag_bits     = out_result_reg.flag_bits;
    assign decode.immediate     = out_result_reg.immediate;
    assign decode.branch_target = out_result_reg.branch_target;

    // An accepted request always lands in the input stage.
    `AIC_ASSERT_NEXT(a_accept_fills_input, clk, rst_n, fetch_accept, in_valid_reg)
    // A request waiting in the input stage behind a stalled result stays there.
    `AIC_ASSERT_NEXT(a_input_held, clk, rst_n, in_valid_reg && !out_free, in_valid_reg)
    // The never condition cannot produce a known class.
    `AIC_ASSERT_SAME(a_never_unknown, clk, rst_n,
        out_valid_reg && out_result_reg.condition == aic_pkg::COND_NEVER,
        out_result_reg.class_code == aic_pkg::CLS_UNKNOWN)
    // Only branches carry a target.
    `AIC_ASSERT_SAME(a_target_only_branch, clk, rst_n,
        out_valid_reg && out_result_reg.class_code != aic_pkg::CLS_B,
        out_result_reg.branch_target == 32'd0)

endmodule

### sim/aic_decode_checker.sv
// Watches both channels of the classifier, predicts the decode of every
// accepted request and compares each accepted result with the oldest one.
module aic_decode_checker
    import aic_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    aic_fetch_if  fetch,
    aic_decode_if decode,
    output int    mismatches,
    output int    pending,
    output int    checked,
    output int    classes_seen
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed
    {
        logic [31:0]    word;
        decode_result_t result;
    } awaited_decode_t;

    awaited_decode_t decodes_awaited[$];
    logic [23:0]     class_hits = '0;
    int              mismatch_count = 0;
    int              checked_count = 0;

    assign mismatches   = mismatch_count;
    assign pending      = decodes_awaited.size();
    assign checked      = checked_count;
    assign classes_seen = $countones(class_hits);

    // Decode of one word as the classifier must give it.
    function automatic decode_result_t predict_decode(input logic [31:0] w,
                                                      input logic [31:0] pc);
        decode_result_t r;
        class_code_t    cls;
        logic [31:0]    imm8;
        logic [63:0]    doubled;
        begin
            cls = CLS_UNKNOWN;
            if (w[31:28] != COND_NEVER)
            begin
                case (w[27:25])
                    GRP_DP_REG:
                    begin
                        if (!w[4])
                        begin
                            if ((w & MASK_MSR_REG) == MATCH_MSR)
                                cls = CLS_MSR_REG;
                            else if ((w & MASK_MRS) == MATCH_MRS)
                                cls = CLS_MRS;
                            else
                                cls = CLS_DP_SHIFT_IMM;
                        end
                        else if (!w[7])
                        begin
                            if (w[24:23] == MULK_MISC && !w[20])
                            begin
                                if ((w & MASK_BX) == MATCH_BX)
                                    cls = CLS_BX;
                                else if (w[6:5] == 2'b00 && w[24:21] == OPC_CLZ)
                                    cls = CLS_CLZ;
                            end
                            else
                            begin
                                cls = CLS_DP_SHIFT_REG;
                            end
                        end
                        else
                        begin
                            case (w[6:5])
                                XLS_SWP_MUL:
                                begin
                                    if (w[24:23] == MULK_SHORT)
                                    begin
                                        if (!w[22])
                                            cls = CLS_MUL;
                                    end
                                    else if (w[24:23] == MULK_LONG)
                                        cls = CLS_MUL_LONG;
                                    else if (w[24:23] == MULK_MISC && w[21:20] == 2'b00
                                             && w[11:8] == 4'h0)
                                        cls = CLS_SWP;
                                end
                                XLS_HALF:
                                begin
                                    if (w[22])
                                        cls = CLS_LDRH_IMM;
                                    else if (w[11:8] == 4'h0)
                                        cls = CLS_LDRH_REG;
                                end
                                XLS_SBYTE:
                                begin
                                    if (w[22])
                                        cls = CLS_LDRSB_IMM;
                                    else if (w[11:8] == 4'h0)
                                        cls = CLS_LDRSB_REG;
                                    // A signed load with L clear is a doubleword transfer.
                                    if (!w[20])
                                        cls = CLS_UNKNOWN;
                                end
                                default:
                                begin
                                    if (w[22])
                                        cls = CLS_LDRSH_IMM;
                                    else if (w[11:8] == 4'h0)
                                        cls = CLS_LDRSH_REG;
                                    if (!w[20])
                                        cls = CLS_UNKNOWN;
                                end
                            endcase
                        end
                    end
                    GRP_DP_IMM:
                    begin
                        if ((w & MASK_MSR_IMM) == MATCH_MSR)
                            cls = CLS_MSR_IMM;
                        else if ((w & MASK_STATUS) != MATCH_STATUS)
                            cls = CLS_DP_IMM;
                    end
                    GRP_LS_IMM: cls = CLS_LDR_IMM;
                    GRP_LS_REG:
                    begin
                        if (!w[4])
                            cls = CLS_LDR_REG;
                    end
                    GRP_LDM:    cls = CLS_LDM;
                    GRP_BRANCH: cls = CLS_B;
                    GRP_CP_LS:  cls = CLS_UNKNOWN;
                    default:
                    begin
                        if (w[24])
                            cls = CLS_SWI;
                        else if (w[4])
                            cls = CLS_MCR;
                    end
                endcase
            end

            r = '0;
            r.class_code  = cls;
            r.condition   = w[31:28];
            r.dest_reg    = w[15:12];
            r.first_reg   = w[19:16];
            r.second_reg  = w[3:0];
            r.shift_reg   = w[11:8];
            r.alu_opcode  = w[24:21];
            r.shift_kind  = w[6:5];
            r.shift_count = w[11:7];
            r.flag_bits   = w[24:20];

            case (cls)
                CLS_MSR_IMM, CLS_DP_IMM:
                begin
                    // Rotating the doubled value right keeps the wrapped bits,
                    // and a zero rotation leaves the plain byte.
                    imm8        = {24'd0, w[7:0]};
                    doubled     = {imm8, imm8} >> {w[11:8], 1'b0};
                    r.immediate = doubled[31:0];
                end
                CLS_LDR_IMM:
                    r.immediate = {20'd0, w[11:0]};
                CLS_LDRH_IMM, CLS_LDRSB_IMM, CLS_LDRSH_IMM:
                    r.immediate = {24'd0, w[11:8], w[3:0]};
                CLS_SWI:
                    r.immediate = {8'd0, w[23:0]};
                default:
                    r.immediate = '0;
            endcase

            if (cls == CLS_B)
                r.branch_target = pc + PC_AHEAD + {{6{w[23]}}, w[23:0], 2'b00};
            return r;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        awaited_decode_t head;
        decode_result_t  got;
        decode_result_t  want;
        string           bad;
        if (rst_n)
        begin
            if (decode.valid && decode.ready)
            begin
                got.class_code    = class_code_t'(decode.class_code);
                got.condition     = decode.condition;
                got.dest_reg      = decode.dest_reg;
                got.first_reg     = decode.first_reg;
                got.second_reg    = decode.second_reg;
                got.shift_reg     = decode.shift_reg;
                got.alu_opcode    = decode.alu_opcode;
                got.shift_kind    = decode.shift_kind;
                got.shift_count   = decode.shift_count;
                got.flag_bits     = decode.flag_bits;
                got.immediate     = decode.immediate;
                got.branch_target = decode.branch_target;
                if (decodes_awaited.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("decode result with no request outstanding: %p", got);
                end
                else
                begin
                    head = decodes_awaited.pop_front();
                    want = head.result;
                    checked_count++;
                    bad = "";
                    if (got.class_code !== want.class_code)       bad = {bad, " class_code"};
                    if (got.condition !== want.condition)         bad = {bad, " condition"};
                    if (got.dest_reg !== want.dest_reg)           bad = {bad, " dest_reg"};
                    if (got.first_reg !== want.first_reg)         bad = {bad, " first_reg"};
                    if (got.second_reg !== want.second_reg)       bad = {bad, " second_reg"};
                    if (got.shift_reg !== want.shift_reg)         bad = {bad, " shift_reg"};
                    if (got.alu_opcode !== want.alu_opcode)       bad = {bad, " alu_opcode"};
                    if (got.shift_kind !== want.shift_kind)       bad = {bad, " shift_kind"};
                    if (got.shift_count !== want.shift_count)     bad = {bad, " shift_count"};
                    if (got.flag_bits !== want.flag_bits)         bad = {bad, " flag_bits"};
                    if (got.immediate !== want.immediate)         bad = {bad, " immediate"};
                    if (got.branch_target !== want.branch_target) bad = {bad, " branch_target"};
                    if (bad != "")
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("decode mismatch for word %h, wrong:%s", head.word, bad);
                            $display("  expected %p", want);
                            $display("  actual   %p", got);
                        end
                    end
                end
            end

            if (fetch.valid && fetch.ready)
            begin
                head.word   = fetch.instruction;
                head.result = predict_decode(fetch.instruction, fetch.fetch_address);
                class_hits[head.result.class_code] = 1'b1;
                decodes_awaited.push_back(head);
            end
        end
    end

endmodule

### sim/armv5_instruction_classifier_tb.sv
// Top of the classifier testbench. It only makes stimulus and gives the
// verdict: the checker beside the block watches both channels, predicts the
// decode of every request and counts mismatches.
module armv5_instruction_classifier_tb;
    import aic_pkg::*;

    localparam int RANDOM_REQUESTS = 1900;
    // Every third stretch of this many handshakes runs with no idling on that side.
    localparam int QUIET_SPAN      = 150;
    // Cycles allowed for the result queue to empty once the sender stops.
    localparam int DRAIN_LIMIT     = 2000;
    // Cycles waited after the last drain so that any stray result is caught.
    localparam int SETTLE_CYCLES   = 10;
    localparam int DIRECTED_COUNT  = 27;

    // Hand-picked words: one of every class, the condition-never word, the
    // doubleword form of a signed load, an immediate in the undefined status
    // space, a zero rotation and branches that wrap in both directions.
    localparam logic [31:0] DIRECTED_WORDS [DIRECTED_COUNT] = '{
        32'hFFFF_FFFF, // condition never, every bit set
        32'hE129_F001, // msr from a register
        32'hE10F_0000, // mrs
        32'hE081_21C3, // data processing, immediate shift
        32'hE12F_FF1E, // bx
        32'hE16F_1F12, // clz
        32'hE081_2314, // data processing, register shift
        32'hE000_0291, // mul
        32'hE081_0392, // long multiply
        32'hE101_0092, // swp
        32'hE1D1_2AB5, // halfword load, split immediate
        32'hE191_00B2, // halfword load, register
        32'hE1D1_2FDF, // signed byte load, immediate
        32'hE191_00D2, // signed byte load, register
        32'hE1C1_00D8, // signed load with L clear: doubleword, unknown
        32'hE1D1_00F0, // signed halfword load, immediate
        32'hE191_00F2, // signed halfword load, register
        32'hE328_F0FF, // msr immediate with zero rotation
        32'hE3A0_0F81, // data processing immediate, rotation by 30
        32'hE300_0000, // immediate in the undefined status space: unknown
        32'hE591_2FFF, // word load, largest offset
        32'hE791_2003, // word load, register offset
        32'hE8BD_000F, // ldm
        32'hEA7F_FFFF, // branch, largest forward offset
        32'hEA80_0000, // branch, largest backward offset
        32'hEF12_3456, // swi
        32'hEE01_0F10  // mcr
    };

    localparam logic [31:0] DIRECTED_ADDRS [DIRECTED_COUNT] = '{
        32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0004, 32'h0000_8000,
        32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFC, 32'h0000_0100,
        32'hDEAD_BEEC, 32'h0000_0010, 32'h0000_0020, 32'h0000_0030,
        32'h0000_0040, 32'h0000_0050, 32'h0000_0060, 32'h0000_0070,
        32'h0000_0080, 32'h0000_0090, 32'h0000_00A0, 32'h0000_00B0,
        32'h0000_00C0, 32'h0000_00D0, 32'h0000_00E0, 32'hFFFF_FFF0,
        32'h0000_0000, 32'h0000_0200, 32'h0000_0300
    };

    logic clk;
    logic rst_n;

    aic_fetch_if  fetch_ch();
    aic_decode_if decode_ch();

    int mismatches;
    int pending;
    int checked;
    int classes_seen;
    int requests_sent = 0;
    int results_taken = 0;

    armv5_instruction_classifier dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fetch  (fetch_ch),
        .decode (decode_ch)
    );

    aic_decode_checker decode_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fetch        (fetch_ch),
        .decode       (decode_ch),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .classes_seen (classes_seen)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offers one request after a random gap and returns at the edge where it
    // is taken. It is always entered just after a rising edge, so every drive
    // lands on an edge; when the gap is zero valid simply stays high.
    task automatic send_request(input logic [31:0] word, input logic [31:0] addr);
        int gap;
        begin
            gap = ((requests_sent / QUIET_SPAN) % 3 == 1) ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                fetch_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            fetch_ch.valid         <= 1'b1;
            fetch_ch.instruction   <= word;
            fetch_ch.fetch_address <= addr;
            @(posedge clk);
            while (!fetch_ch.ready)
                @(posedge clk);
            requests_sent++;
        end
    endtask

    // Holds the sender off until every predicted decode has come back. The
    // checker updates its queue on the rising edge, so the count is read on
    // the falling edge; the task returns on a rising edge again.
    task automatic wait_for_drain();
        int waited;
        begin
            waited = 0;
            fetch_ch.valid <= 1'b0;
            @(negedge clk);
            while (pending != 0 && waited < DRAIN_LIMIT)
            begin
                @(negedge clk);
                waited++;
            end
            @(posedge clk);
        end
    endtask

    // The result side stalls for a random number of cycles before every
    // result, except in its own quiet stretches, where ready stays high.
    initial
    begin : result_sink
        int stall;
        decode_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = ((results_taken / QUIET_SPAN) % 3 == 2) ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                decode_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            decode_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(decode_ch.valid && decode_ch.ready))
                @(posedge clk);
            results_taken++;
        end
    end

    initial
    begin : stimulus
        logic [31:0] word;
        logic [31:0] addr;
        int          pick;
        int          flip;

        rst_n                  <= 1'b0;
        fetch_ch.valid         <= 1'b0;
        fetch_ch.instruction   <= '0;
        fetch_ch.fetch_address <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_WORDS[i])
            send_request(DIRECTED_WORDS[i], DIRECTED_ADDRS[i]);
        // The sender stops here until every directed request has come back.
        wait_for_drain();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // Start from a random word, mostly with a live condition, then
            // usually force it into one of the encoding families so that the narrow
            // patterns (status moves, bx, clz, the extra loads and stores)
            // are reached with random content around them.
            word = $urandom;
            if ($urandom_range(0, 15) != 0)
                word[31:28] = 4'($urandom_range(0, 14));
            pick = $urandom_range(0, 11);
            case (pick)
                1:
                begin
                    word        = (word & ~MASK_MSR_REG) | MATCH_MSR;
                    word[27:25] = GRP_DP_REG;
                    word[4]     = 1'b0;
                end
                2:
                begin
                    word        = (word & ~MASK_MRS) | MATCH_MRS;
                    word[27:25] = GRP_DP_REG;
                end
                3:
                begin
                    word        = (word & ~MASK_BX) | MATCH_BX;
                    word[27:25] = GRP_DP_REG;
                    word[4]     = 1'b1;
                end
                4:
                begin
                    word[27:25] = GRP_DP_REG;
                    word[24:20] = {OPC_CLZ, 1'b0};
                    word[7:4]   = 4'b0001;
                end
                5, 6:
                begin
                    // Multiplies, swaps and the extra loads and stores; a zero
                    // register field is needed for the register forms.
                    word[27:25] = GRP_DP_REG;
                    word[7]     = 1'b1;
                    word[4]     = 1'b1;
                    if ($urandom_range(0, 1) == 1)
                        word[11:8] = 4'h0;
                end
                7:
                    word[27:25] = GRP_DP_REG;
                8:
                begin
                    word[27:25] = GRP_DP_IMM;
                    if ($urandom_range(0, 1) == 1)
                        word = (word & ~MASK_MSR_IMM) | MATCH_MSR;
                end
                9:
                    word[27:25] = 3'($urandom_range(GRP_LS_IMM, GRP_LS_REG));
                10:
                    word[27:25] = 3'($urandom_range(GRP_LDM, GRP_SWI_CP));
                default:
                    ;
            endcase
            // Now and then one bit is flipped so that near misses of each
            // pattern turn up as well.
            if ($urandom_range(0, 7) == 0)
            begin
                flip       = $urandom_range(0, 27);
                word[flip] = ~word[flip];
            end

            // Addresses near both ends of the space make branch targets wrap.
            case ($urandom_range(0, 7))
                0:       addr = 32'($urandom_range(0, 255));
                1:       addr = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
                default: addr = $urandom;
            endcase

            send_request(word, addr);
            if (n == RANDOM_REQUESTS / 2)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("run covered %0d requests and %0d checked decodes, %0d of 24 classes hit",
                 requests_sent, checked, classes_seen);
        $display("mismatches %0d, decodes still outstanding %0d", mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #3600000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/aic_pkg.sv
rtl/aic_channels.sv
rtl/aic_decode.sv
rtl/armv5_instruction_classifier.sv
sim/aic_decode_checker.sv
sim/armv5_instruction_classifier_tb.sv
